// ===== rtl/go_to_goal_p_controller_defines.svh =====
// Assertion macros for the go-to-goal controller checker.
// No dependencies; included by the checker file only.
`ifndef GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH

// Clocked property, masked while reset is held.
`define GGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define GGP_NEVER(lbl, cond, msg) \
  `GGP_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/ggp_pkg.sv =====
// Shared types, constants and helpers of the go-to-goal controller.
// No dependencies.
`default_nettype none
package ggp_pkg;

  localparam int PI_Q12       = 12868;
  localparam int TWO_PI_Q12   = 25736;
  localparam int PI_Q16       = 205887;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 17;   // result bits of the root
  localparam int NUM_CELLS    = 17;   // max of the two step counts

  localparam logic [7:0] DIST_GAIN_RST = 8'd128;
  localparam logic [8:0] BEAR_GAIN_RST = 9'd256;
  localparam logic [6:0] DIST_TOL_RST  = 7'd102;
  localparam logic [6:0] HEAD_TOL_RST  = 7'd70;

  // register indexes
  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_GOAL_HEAD = 3'd2;
  localparam logic [2:0] REG_DIST_GAIN = 3'd3;
  localparam logic [2:0] REG_BEAR_GAIN = 3'd4;
  localparam logic [2:0] REG_DIST_TOL  = 3'd5;
  localparam logic [2:0] REG_HEAD_TOL  = 3'd6;

  // data handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;        // CORDIC vector
    logic signed [31:0] y;
    logic signed [21:0] z;        // angle, Q16
    logic        [34:0] rem;      // root remainder
    logic        [34:0] root;
    logic signed [14:0] hd;       // heading
    logic        [13:0] ferr_abs; // |final heading error|
    logic               zero;     // robot on the goal point
  } ggp_cell_t;

  function automatic logic signed [21:0] atan_q16(input logic [3:0] i);
    logic signed [21:0] t;
    unique case (i)
      4'd0:  t = 22'sd51472;
      4'd1:  t = 22'sd30386;
      4'd2:  t = 22'sd16055;
      4'd3:  t = 22'sd8150;
      4'd4:  t = 22'sd4091;
      4'd5:  t = 22'sd2047;
      4'd6:  t = 22'sd1024;
      4'd7:  t = 22'sd512;
      4'd8:  t = 22'sd256;
      4'd9:  t = 22'sd128;
      4'd10: t = 22'sd64;
      4'd11: t = 22'sd32;
      4'd12: t = 22'sd16;
      4'd13: t = 22'sd8;
      4'd14: t = 22'sd4;
      default: t = 22'sd2;
    endcase
    return t;
  endfunction

  // One fold into [-pi, pi]; inputs never exceed 3*pi in magnitude.
  function automatic logic signed [15:0] wrap_pi(input logic signed [16:0] e);
    logic signed [16:0] r;
    r = e;
    if (e > 17'sd12868) r = e - 17'sd25736;
    else if (e < -17'sd12868) r = e + 17'sd25736;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/go_to_goal_p_controller.sv =====
// Go-to-goal P controller. Throughput: one pose per cycle; the whole pipeline holds
// while a result waits on out_tready, so in_tready follows the output register.
// Depth is set by the 17-cell chain (16 CORDIC steps, 17 root digits).
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on ggp_pkg and ggp_cell.
`default_nettype none
module go_to_goal_p_controller import ggp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32], pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // linear_speed[14:0], turn_rate[30:15], pad
  output logic        out_tuser,  // goal_reached
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  // configuration registers
  logic signed [15:0] goal_x_r, goal_y_r;
  logic signed [14:0] goal_head_r;
  logic [15:0] dist_gain_r, bear_gain_r, dist_tol_r;
  logic [13:0] head_tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_head_r <= '0;
      dist_gain_r <= 16'(DIST_GAIN_RST);
      bear_gain_r <= 16'(BEAR_GAIN_RST);
      dist_tol_r  <= 16'(DIST_TOL_RST);
      head_tol_r  <= 14'(HEAD_TOL_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GOAL_X:    goal_x_r    <= cfg_data;
        REG_GOAL_Y:    goal_y_r    <= cfg_data;
        REG_GOAL_HEAD: goal_head_r <= cfg_data[14:0];
        REG_DIST_GAIN: dist_gain_r <= cfg_data;
        REG_BEAR_GAIN: bear_gain_r <= cfg_data;
        REG_DIST_TOL:  dist_tol_r  <= cfg_data;
        REG_HEAD_TOL:  head_tol_r  <= cfg_data[13:0];
        default: ;     // unknown index: write dropped
      endcase
    end
  end

  // Global advance: everything moves unless a result is stuck at the output.
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---- stage 0: differences and final heading error ----
  logic signed [15:0] pos_x, pos_y;
  logic signed [14:0] heading;
  assign pos_x   = in_tdata[15:0];
  assign pos_y   = in_tdata[31:16];
  assign heading = in_tdata[46:32];

  logic s0_valid_r;
  logic signed [16:0] s0_dx_r, s0_dy_r;
  logic signed [14:0] s0_hd_r;
  logic [13:0] s0_ferr_r;
  logic signed [15:0] ferr_w;

  assign ferr_w = wrap_pi(17'(goal_head_r) - 17'(heading));

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx_r   <= 17'(goal_x_r) - 17'(pos_x);
      s0_dy_r   <= 17'(goal_y_r) - 17'(pos_y);
      s0_hd_r   <= heading;
      s0_ferr_r <= (ferr_w < 0) ? 14'(-ferr_w) : 14'(ferr_w);
    end
  end

  // ---- stage 1: squared distance and CORDIC pre-rotation ----
  ggp_cell_t chain [NUM_CELLS+1];
  ggp_cell_t s1_r;
  logic signed [33:0] dx_sq, dy_sq;
  logic signed [31:0] dx_ext, dy_ext;

  assign dx_sq  = s0_dx_r * s0_dx_r;
  assign dy_sq  = s0_dy_r * s0_dy_r;
  assign dx_ext = 32'(s0_dx_r) <<< 12;
  assign dy_ext = 32'(s0_dy_r) <<< 12;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (en) begin
      s1_r.valid    <= s0_valid_r;
      s1_r.rem      <= 35'(dx_sq) + 35'(dy_sq);
      s1_r.root     <= '0;
      s1_r.hd       <= s0_hd_r;
      s1_r.ferr_abs <= s0_ferr_r;
      s1_r.zero     <= (s0_dx_r == 17'sd0) && (s0_dy_r == 17'sd0);
      // left half-plane: flip the vector, start from +-pi
      if (s0_dx_r < 0) begin
        s1_r.x <= -dx_ext;
        s1_r.y <= -dy_ext;
        s1_r.z <= (s0_dy_r >= 0) ? 22'(PI_Q16) : -22'(PI_Q16);
      end else begin
        s1_r.x <= dx_ext;
        s1_r.y <= dy_ext;
        s1_r.z <= '0;
      end
    end
  end

  assign chain[0] = s1_r;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    ggp_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  ggp_cell_t tail;
  assign tail = chain[NUM_CELLS];

  // ---- E1: bearing rounding and wrap, goal test ----
  logic signed [21:0] z_rnd;
  logic signed [15:0] bearing_w;
  logic e1_valid_r, e1_reached_r;
  logic [16:0] e1_dist_r;
  logic signed [15:0] e1_berr_r;
  logic [16:0] dist_w;

  assign z_rnd     = (tail.z + 22'sd8) >>> 4;
  assign bearing_w = tail.zero ? 16'sd0 : z_rnd[15:0];
  assign dist_w    = tail.root[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) e1_valid_r <= 1'b0;
    else if (en) e1_valid_r <= tail.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_dist_r    <= dist_w;
      e1_berr_r    <= wrap_pi(17'(bearing_w) - 17'(tail.hd));
      e1_reached_r <= (dist_w <= 17'(dist_tol_r)) && (tail.ferr_abs <= head_tol_r);
    end
  end

  // ---- E2: gain products ----
  logic e2_valid_r, e2_reached_r;
  logic [32:0] e2_lin_r;
  logic signed [32:0] e2_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e2_valid_r <= 1'b0;
    else if (en) e2_valid_r <= e1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_lin_r     <= dist_gain_r * e1_dist_r;
      e2_ang_r     <= $signed({1'b0, bear_gain_r}) * e1_berr_r;
      e2_reached_r <= e1_reached_r;
    end
  end

  // ---- output register: rounding, saturation and zeroing on goal reached ----
  logic [33:0] lin_rnd;
  logic signed [33:0] ang_rnd;
  logic [14:0] lin_sat;
  logic signed [15:0] ang_sat;
  logic [14:0] out_lin_r;
  logic signed [15:0] out_ang_r;
  logic out_reached_r;

  assign lin_rnd = (34'(e2_lin_r) + 34'd128) >> 8;
  assign ang_rnd = (34'(e2_ang_r) + 34'sd128) >>> 8;
  assign lin_sat = (lin_rnd > 34'd32767) ? 15'h7FFF : lin_rnd[14:0];

  always_comb begin
    if (ang_rnd > 34'sd32767) ang_sat = 16'sh7FFF;
    else if (ang_rnd < -34'sd32768) ang_sat = -16'sh8000;
    else ang_sat = ang_rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= e2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lin_r     <= e2_reached_r ? '0 : lin_sat;
      out_ang_r     <= e2_reached_r ? '0 : ang_sat;
      out_reached_r <= e2_reached_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ang_r, out_lin_r};
  assign out_tuser  = out_reached_r;

endmodule
`default_nettype wire

// ===== rtl/ggp_cell.sv =====
// One cell of the chain: a square-root digit and, in the first CORDIC_STEPS cells, a CORDIC vectoring step.
// Depends on ggp_pkg.
`default_nettype none
module ggp_cell import ggp_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             en,
  input  wire ggp_cell_t  cell_in,
  output ggp_cell_t       cell_out
);

  localparam logic [34:0] SQ_BIT = 35'(1) << (2 * (SQRT_STEPS - 1 - IDX));

  ggp_cell_t cell_r, cell_nxt;
  logic signed [31:0] xs, ys;
  logic [34:0] trial;

  always_comb begin
    cell_nxt = cell_in;
    xs = cell_in.x >>> IDX;
    ys = cell_in.y >>> IDX;
    if (IDX < CORDIC_STEPS) begin
      if (cell_in.y > 32'sd0) begin
        cell_nxt.x = cell_in.x + ys;
        cell_nxt.y = cell_in.y - xs;
        cell_nxt.z = cell_in.z + atan_q16(4'(IDX));
      end else begin
        cell_nxt.x = cell_in.x - ys;
        cell_nxt.y = cell_in.y + xs;
        cell_nxt.z = cell_in.z - atan_q16(4'(IDX));
      end
    end
    trial = cell_in.root + SQ_BIT;
    if (cell_in.rem >= trial) begin
      cell_nxt.rem  = cell_in.rem - trial;
      cell_nxt.root = (cell_in.root >> 1) + SQ_BIT;
    end else begin
      cell_nxt.root = cell_in.root >> 1;
    end
  end

  // only the valid bit is cleared by reset; payload is don't-care then
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

// ===== rtl/ggp_checker.sv =====
// Port-level checks for the go-to-goal controller, bound to the top level.
// Depends on go_to_goal_p_controller_defines.svh.
`default_nettype none
`include "go_to_goal_p_controller_defines.svh"
module ggp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser
);

  `GGP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `GGP_ASSERT(a_ready_free, !out_tvalid |-> in_tready, "input stalled with empty output")
  `GGP_NEVER(a_reached_zero, out_tvalid && out_tuser && (out_tdata != 32'd0),
             "goal reached with nonzero command")
  `GGP_NEVER(a_pad_zero, out_tvalid && out_tdata[31], "padding bit set")

endmodule

bind go_to_goal_p_controller ggp_checker u_ggp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
